FILE: rtl/core/polyphonic_wrapping_step_counter_core_assert.svh
// Assertion macros shared by the counter core.
`ifndef POLYPHONIC_WRAPPING_STEP_COUNTER_CORE_ASSERT_SVH
`define POLYPHONIC_WRAPPING_STEP_COUNTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that a implies b in the same cycle.
`define PWSC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("implication check failed");
// Check that a implies b in the next cycle.
`define PWSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define PWSC_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define PWSC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: rtl/core/pwsc_pkg.sv
package pwsc_pkg;

  localparam int CHANNELS_DEFAULT = 16;
  localparam int CH_W      = 4;
  localparam int MV_W      = 15;
  localparam int COUNT_W   = 24;
  localparam int ACC_W     = 27;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [ACC_W-1:0] COUNT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] OUT_LIMIT = ACC_W'(10000);

  localparam logic signed [MV_W-1:0] START_RESET = MV_W'(0);
  localparam logic signed [MV_W-1:0] END_RESET   = MV_W'(10000);
  localparam logic signed [MV_W-1:0] INC_RESET   = MV_W'(1000);
  localparam logic signed [MV_W-1:0] LOW_RESET   = MV_W'(0);
  localparam logic signed [MV_W-1:0] HIGH_RESET  = MV_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 3'd0,
    CFG_END    = 3'd1,
    CFG_INC    = 3'd2,
    CFG_LOW    = 3'd3,
    CFG_HIGH   = 3'd4,
    CFG_SHARED = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic armed;
    logic rise;
  } schmitt_t;

  // One Schmitt step: drop to low at or below low, fire on reaching high.
  function automatic schmitt_t schmitt_step(logic armed, logic signed [MV_W-1:0] v,
                                            logic signed [MV_W-1:0] low,
                                            logic signed [MV_W-1:0] high);
    schmitt_t r;
    r.armed = armed;
    r.rise  = 1'b0;
    if (armed) begin
      if (v <= low) r.armed = 1'b0;
    end else if (v >= high) begin
      r.armed = 1'b1;
      r.rise  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W-1:0] v,
                                                      logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

FILE: rtl/core/pwsc_count_mem.sv
module pwsc_count_mem
  import pwsc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [IDX_W-1:0]          rd_addr_i,
  output logic signed [COUNT_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_addr_i,
  input  logic signed [COUNT_W-1:0] wr_data_i
);

  logic signed [COUNT_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]       valid_q;
  logic signed [COUNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Forward a same-cycle write; an unwritten entry reads as zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) rd_data_q <= wr_data_i;
      else if (valid_q[rd_addr_i])             rd_data_q <= mem[rd_addr_i];
      else                                     rd_data_q <= '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/polyphonic_wrapping_step_counter_core.sv
// Polyphonic wrapping step counter. Each accepted item carries one channel's
// trigger and reset voltages (mV); each yields exactly one result item with
// the channel and its count clamped to +/-10000 mV. The block takes one item
// per clock cycle while the result side is not stalled. The edge that accepts
// an item loads the item register and reads the count memory; one add/fold
// pass then fills the result register, which presents it, as stage one advances.
// Back-to-back items for the same channel see each other's update through a
// write-to-read bypass on the count memory. Stall on the result side holds
// the pipe; the input stalls only when both stages are full. Configuration
// writes are always taken (cfg_ready_o is high) and must only be issued
// while no items are in flight.
module polyphonic_wrapping_step_counter_core
  import pwsc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input item channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CH_W-1:0]        channel_i,
  input  logic signed [MV_W-1:0] trigger_mv_i,
  input  logic signed [MV_W-1:0] reset_mv_i,
  // result item channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CH_W-1:0]        out_channel_o,
  output logic signed [MV_W-1:0] count_mv_o,
  // configuration write port
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MV_W-1:0]        cfg_data_i
);

`include "polyphonic_wrapping_step_counter_core_assert.svh"

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHX_W = 7;
  localparam logic [CHX_W-1:0] CH_LIMIT = CHX_W'(CHANNELS);

  // Configuration registers.
  logic signed [MV_W-1:0] start_q, end_q, inc_q, low_q, high_q;
  logic                   shared_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= START_RESET;
      end_q    <= END_RESET;
      inc_q    <= INC_RESET;
      low_q    <= LOW_RESET;
      high_q   <= HIGH_RESET;
      shared_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START:  start_q  <= cfg_data_i;
        CFG_END:    end_q    <= cfg_data_i;
        CFG_INC:    inc_q    <= cfg_data_i;
        CFG_LOW:    low_q    <= cfg_data_i;
        CFG_HIGH:   high_q   <= cfg_data_i;
        CFG_SHARED: shared_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipe control: the compute stage advances when the result register is
  // free or being taken; stage one reloads when empty or advancing.
  logic                   a_valid_q;
  logic [CH_W-1:0]        a_ch_q;
  logic signed [MV_W-1:0] a_trig_q, a_rst_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  logic [CHX_W-1:0] in_chx;
  logic             in_in_range;
  assign in_chx      = CHX_W'(channel_i);
  assign in_in_range = in_chx < CH_LIMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_valid_q || advance) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_ch_q   <= channel_i;
      a_trig_q <= trigger_mv_i;
      a_rst_q  <= reset_mv_i;
    end
  end

  // Compute stage.
  logic [CHX_W-1:0]          a_chx;
  logic [IDX_W-1:0]          a_idx;
  logic                      a_in_range;
  logic                      commit;
  logic signed [COUNT_W-1:0] rd_count;
  logic signed [COUNT_W-1:0] new_count;
  logic signed [MV_W-1:0]    out_count_d;

  logic [CHANNELS-1:0] trig_armed_q, rst_armed_q, pending_q;
  logic [CHANNELS-1:0] trig_armed_d, rst_armed_d, pending_d;

  assign a_chx      = CHX_W'(a_ch_q);
  assign a_idx      = a_chx[IDX_W-1:0];
  assign a_in_range = a_chx < CH_LIMIT;
  assign commit     = a_valid_q && advance && a_in_range;

  pwsc_count_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept && in_in_range),
    .rd_addr_i (in_chx[IDX_W-1:0]),
    .rd_data_o (rd_count),
    .wr_en_i   (commit),
    .wr_addr_i (a_idx),
    .wr_data_i (new_count)
  );

  always_comb begin
    logic signed [MV_W-1:0]  lo, hi;
    logic signed [ACC_W-1:0] lo_x, hi_x, c, oc;
    logic                    use_rst;
    schmitt_t                rs, ts;

    // Order the range bounds.
    if (start_q > end_q) begin
      lo = end_q;
      hi = start_q;
    end else begin
      lo = start_q;
      hi = end_q;
    end
    lo_x = ACC_W'(lo);
    hi_x = ACC_W'(hi);

    trig_armed_d = trig_armed_q;
    rst_armed_d  = rst_armed_q;
    pending_d    = pending_q;

    c = ACC_W'(rd_count);

    // A pending shared reset lands first.
    if (pending_q[a_idx]) begin
      pending_d[a_idx] = 1'b0;
      c = lo_x;
    end

    // In shared mode only channel 0 looks at its reset input.
    use_rst = !shared_q || (a_ch_q == '0);
    rs = schmitt_step(rst_armed_q[a_idx], a_rst_q, low_q, high_q);
    if (use_rst) begin
      rst_armed_d[a_idx] = rs.armed;
      if (rs.rise) begin
        c = lo_x;
        if (shared_q) pending_d = pending_d | ~CHANNELS'(1);
      end
    end

    // Step, then fold above and below the range once each.
    ts = schmitt_step(trig_armed_q[a_idx], a_trig_q, low_q, high_q);
    trig_armed_d[a_idx] = ts.armed;
    if (ts.rise) begin
      c = sat_acc(c + ACC_W'(inc_q), COUNT_MAX);
      if (c > hi_x) c = lo_x + (c - hi_x);
      if (c < lo_x) c = hi_x - (lo_x - c);
      c = sat_acc(c, COUNT_MAX);
    end

    new_count   = c[COUNT_W-1:0];
    oc          = sat_acc(c, OUT_LIMIT);
    out_count_d = a_in_range ? oc[MV_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_armed_q <= '1;
      rst_armed_q  <= '1;
      pending_q    <= '0;
    end else if (commit) begin
      trig_armed_q <= trig_armed_d;
      rst_armed_q  <= rst_armed_d;
      pending_q    <= pending_d;
    end
  end

  // Result register.
  logic [CH_W-1:0]        out_channel_q;
  logic signed [MV_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && a_valid_q) begin
      out_channel_q <= a_ch_q;
      out_count_q   <= out_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign count_mv_o    = out_count_q;

  // Input stalls only behind a held result.
  `PWSC_ASSERT_IMPLY(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_q && out_stall_i)
  // A stage-one item held by backpressure stays put.
  `PWSC_ASSERT_NEXT(a_hold, clk_i, rst_ni, a_valid_q && !advance, a_valid_q && $stable(a_ch_q))
  // Results stay within the output clamp.
  `PWSC_ASSERT_IMPLY(a_out_clamp, clk_i, rst_ni, out_valid_q,
                     (out_count_q <= 15'sd10000) && (out_count_q >= -15'sd10000))
  // A channel beyond the configured count reports zero.
  `PWSC_ASSERT_IMPLY(a_out_of_range_zero, clk_i, rst_ni,
                     out_valid_q && (CHX_W'(out_channel_q) >= CH_LIMIT), out_count_q == '0)

endmodule
